>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define LHM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define LHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lhm_pkg.sv
// ----------------------------------------------------------------------------
// lhm_pkg
// Shared field widths, codes and controller/datapath interface types for the
// latency histogram monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package lhm_pkg;

  // Transaction field widths
  localparam int LAT_W  = 40;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 64;
  localparam int PCTL_W = 24;
  localparam int SLOT_W = 6;
  localparam int PCT_W  = 7;

  // Percent scale of the percentile target
  localparam int PCT_SCALE = 100;

  // Transaction kind code
  localparam logic KIND_QUERY = 1'b1;

  // Per-slot statistics word
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] err;
    logic [TOT_W-1:0] tot;
    logic [LAT_W-1:0] peak;
    logic [CNT_W-1:0] ovf;
  } stat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic stat_rd;
    logic div_start;
    logic bkt_rd;
    logic rec_commit;
    logic tgt_load;
    logic walk_issue;
    logic q_commit;
    logic oor_commit;
    logic clr_step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_query;
    logic oor;
    logic div_busy;
    logic walk_done;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/lhm_div.sv
// ----------------------------------------------------------------------------
// lhm_div
// Bucket indexer: files a latency into its bucket by reciprocal
// multiplication, clamping to the last bucket beyond the histogram range.
// ----------------------------------------------------------------------------
`default_nettype none

module lhm_div #(
  parameter int BUCKETS         = 2048,
  parameter int BUCKET_WIDTH_NS = 5000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lhm_pkg::LAT_W-1:0]   dividend,
  output logic                        busy,
  output logic [$clog2(BUCKETS)-1:0]  bucket,
  output logic                        beyond
);

  localparam int BW = $clog2(BUCKETS);
  localparam longint unsigned LIMIT = 64'(BUCKETS) * 64'(BUCKET_WIDTH_NS);
  // In-range latencies stay below LIMIT, so NW bits hold them
  localparam int NW = $clog2(LIMIT);
  localparam int DL = $clog2(BUCKET_WIDTH_NS);
  localparam int SH = NW + DL;
  // ceil(2^SH / width): exact floor quotient for every NW-bit numerator
  localparam longint unsigned MAGIC =
    ((64'd1 << SH) + 64'(BUCKET_WIDTH_NS) - 64'd1) / 64'(BUCKET_WIDTH_NS);
  localparam int MW = NW + 2;
  localparam int PW = NW + MW;

  logic          busy_r;
  logic          beyond_r;
  logic [NW-1:0] num_r;
  logic [PW-1:0] prod_r;

  // Busy for the one multiply cycle after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  // Capture the latency, then multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (start) begin
      num_r    <= NW'(dividend);
      beyond_r <= (64'(dividend) >= LIMIT);
    end
    if (busy_r) begin
      prod_r <= PW'(num_r) * PW'(MAGIC);
    end
  end

  assign busy   = busy_r;
  assign bucket = beyond_r ? BW'(BUCKETS - 1) : prod_r[SH +: BW];
  assign beyond = beyond_r;

endmodule

`default_nettype wire

>>> hdl/lhm_datapath.sv
// ----------------------------------------------------------------------------
// lhm_datapath
// Input capture, slot statistics store, bucket store with clearing sweep,
// bucket divider, pipelined percentile walk and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lhm_datapath #(
  parameter int SLOTS           = 64,
  parameter int BUCKETS         = 2048,
  parameter int BUCKET_WIDTH_NS = 5000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lhm_pkg::cmd_t                cmd,
  output lhm_pkg::sts_t                sts,
  input  logic                         in_kind,
  input  logic [lhm_pkg::SLOT_W-1:0]   in_metric_slot,
  input  logic [lhm_pkg::LAT_W-1:0]    in_latency_ns,
  input  logic                         in_success,
  input  logic [lhm_pkg::PCT_W-1:0]    in_percent,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lhm_pkg::CNT_W-1:0]    out_sample_count,
  output logic [lhm_pkg::CNT_W-1:0]    out_error_count,
  output logic [lhm_pkg::TOT_W-1:0]    out_latency_total,
  output logic [lhm_pkg::LAT_W-1:0]    out_latency_peak,
  output logic [lhm_pkg::CNT_W-1:0]    out_overflow_count,
  output logic [lhm_pkg::PCTL_W-1:0]   out_percentile_ns
);

  localparam int CW    = lhm_pkg::CNT_W;
  localparam int LW    = lhm_pkg::LAT_W;
  localparam int TW    = lhm_pkg::TOT_W;
  localparam int PW    = lhm_pkg::PCTL_W;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW    = $clog2(BUCKETS);
  localparam int AW    = SW + BW;
  localparam int SCL_W = lhm_pkg::CNT_W + lhm_pkg::PCT_W;
  localparam int ACC_W = lhm_pkg::CNT_W + BW + lhm_pkg::PCT_W;
  localparam longint unsigned EDGE_MAX = 64'(BUCKETS) * 64'(BUCKET_WIDTH_NS);
  localparam int EW    = $clog2(EDGE_MAX + 64'd1);
  localparam logic [lhm_pkg::PCT_W-1:0] SCALE = lhm_pkg::PCT_W'(lhm_pkg::PCT_SCALE);

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (&v) ? v : CW'(v + 1'b1);
  endfunction

  // -------------------------------------------------------------------------
  // Captured transaction
  // -------------------------------------------------------------------------
  logic                       kind_r;
  logic [lhm_pkg::SLOT_W-1:0] slot_r;
  logic [LW-1:0]              lat_r;
  logic                       succ_r;
  logic [lhm_pkg::PCT_W-1:0]  pct_r;
  logic [SW-1:0]              slot_idx;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_kind;
      slot_r <= in_metric_slot;
      lat_r  <= in_latency_ns;
      succ_r <= in_success;
      pct_r  <= in_percent;
    end
  end

  assign slot_idx = SW'(slot_r);

  // -------------------------------------------------------------------------
  // Slot statistics store: valid bit per slot, unwritten slots read as zero
  // -------------------------------------------------------------------------
  lhm_pkg::stat_t  stat_mem_r [2**SW];
  lhm_pkg::stat_t  stat_q_r;
  logic            stat_vq_r;
  logic [2**SW-1:0] slot_vld_r;
  lhm_pkg::stat_t  stat_cur;
  lhm_pkg::stat_t  stat_nxt;

  always_ff @(posedge clk) begin
    if (cmd.stat_rd) begin
      stat_q_r <= stat_mem_r[slot_idx];
    end
    if (cmd.rec_commit) begin
      stat_mem_r[slot_idx] <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      stat_vq_r  <= 1'b0;
    end else begin
      if (cmd.stat_rd) begin
        stat_vq_r <= slot_vld_r[slot_idx];
      end
      if (cmd.rec_commit) begin
        slot_vld_r[slot_idx] <= 1'b1;
      end
    end
  end

  assign stat_cur = stat_vq_r ? stat_q_r : '0;

  // -------------------------------------------------------------------------
  // Bucket index
  // -------------------------------------------------------------------------
  logic          div_busy;
  logic [BW-1:0] div_bucket;
  logic          div_beyond;

  lhm_div #(
    .BUCKETS         (BUCKETS),
    .BUCKET_WIDTH_NS (BUCKET_WIDTH_NS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (lat_r),
    .busy     (div_busy),
    .bucket   (div_bucket),
    .beyond   (div_beyond)
  );

  // Record update of the slot statistics
  always_comb begin
    stat_nxt.cnt  = sat_inc(stat_cur.cnt);
    stat_nxt.err  = succ_r ? stat_cur.err : sat_inc(stat_cur.err);
    stat_nxt.tot  = stat_cur.tot + TW'(lat_r);
    stat_nxt.peak = (lat_r > stat_cur.peak) ? lat_r : stat_cur.peak;
    stat_nxt.ovf  = div_beyond ? sat_inc(stat_cur.ovf) : stat_cur.ovf;
  end

  // -------------------------------------------------------------------------
  // Bucket store: cleared by a sweep after reset
  // -------------------------------------------------------------------------
  logic [CW-1:0] bkt_mem_r [2**AW];
  logic [CW-1:0] bkt_q_r;
  logic [AW-1:0] clr_ctr_r;
  logic [AW-1:0] rec_addr;
  logic [AW-1:0] bkt_raddr;
  logic [AW-1:0] bkt_waddr;
  logic [CW-1:0] bkt_wdata;
  logic          bkt_we;
  logic          bkt_re;
  logic          walk_re;
  logic [BW-1:0] b_iss_r;

  assign rec_addr  = {slot_idx, div_bucket};
  assign bkt_re    = cmd.bkt_rd | walk_re;
  assign bkt_raddr = cmd.bkt_rd ? rec_addr : {slot_idx, b_iss_r};
  assign bkt_we    = cmd.clr_step | cmd.rec_commit;
  assign bkt_waddr = cmd.clr_step ? clr_ctr_r : rec_addr;
  assign bkt_wdata = cmd.clr_step ? '0 : sat_inc(bkt_q_r);

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem_r[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_q_r <= bkt_mem_r[bkt_raddr];
    end
  end

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ctr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_ctr_r <= AW'(clr_ctr_r + 1'b1);
    end
  end

  // -------------------------------------------------------------------------
  // Percentile walk: issue, scale by 100, accumulate and compare.
  // acc >= ceil(count*pct/100) holds exactly when 100*acc >= count*pct.
  // -------------------------------------------------------------------------
  logic             iss_done_r;
  logic             v1_r;
  logic             v2_r;
  logic             found_r;
  logic [EW-1:0]    e_iss_r;
  logic [EW-1:0]    e1_r;
  logic [EW-1:0]    e2_r;
  logic [EW-1:0]    edge_r;
  logic [SCL_W-1:0] scl_r;
  logic [SCL_W-1:0] tgt_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] sum_nxt;

  assign walk_re = cmd.walk_issue && !iss_done_r && !found_r;
  assign sum_nxt = acc_r + ACC_W'(scl_r);

  // Walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_iss_r    <= '0;
      iss_done_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.tgt_load) begin
      b_iss_r    <= '0;
      iss_done_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (walk_re) begin
        b_iss_r    <= BW'(b_iss_r + 1'b1);
        iss_done_r <= (b_iss_r == BW'(BUCKETS - 1));
      end
      v1_r <= walk_re;
      v2_r <= v1_r;
      if (v2_r && !found_r && (sum_nxt >= ACC_W'(tgt_r))) begin
        found_r <= 1'b1;
      end
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    if (cmd.tgt_load) begin
      tgt_r   <= SCL_W'(stat_cur.cnt) * SCL_W'(pct_r);
      acc_r   <= '0;
      e_iss_r <= EW'(BUCKET_WIDTH_NS);
      edge_r  <= '0;
    end else begin
      if (walk_re) begin
        e_iss_r <= EW'(e_iss_r + EW'(BUCKET_WIDTH_NS));
      end
      if (v2_r && !found_r) begin
        acc_r <= sum_nxt;
        if (sum_nxt >= ACC_W'(tgt_r)) begin
          edge_r <= e2_r;
        end
      end
    end
    e1_r  <= e_iss_r;
    e2_r  <= e1_r;
    scl_r <= SCL_W'(bkt_q_r) * SCL_W'(SCALE);
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic           out_valid_r;
  lhm_pkg::stat_t out_stat_r;
  logic [PW-1:0]  out_pctl_r;
  logic           out_free;
  logic           commit;

  assign out_free = !out_valid_r || out_ready;
  assign commit   = cmd.rec_commit | cmd.q_commit | cmd.oor_commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_commit) begin
      out_stat_r <= stat_nxt;
      out_pctl_r <= '0;
    end else if (cmd.q_commit) begin
      out_stat_r <= stat_cur;
      out_pctl_r <= PW'(edge_r);
    end else if (cmd.oor_commit) begin
      out_stat_r <= '0;
      out_pctl_r <= '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_count   = out_stat_r.cnt;
  assign out_error_count    = out_stat_r.err;
  assign out_latency_total  = out_stat_r.tot;
  assign out_latency_peak   = out_stat_r.peak;
  assign out_overflow_count = out_stat_r.ovf;
  assign out_percentile_ns  = out_pctl_r;

  // -------------------------------------------------------------------------
  // Status
  // -------------------------------------------------------------------------
  assign sts.is_query  = (kind_r == lhm_pkg::KIND_QUERY);
  assign sts.oor       = (int'(slot_r) >= SLOTS);
  assign sts.div_busy  = div_busy;
  assign sts.walk_done = found_r || (iss_done_r && !v1_r && !v2_r);
  assign sts.clr_last  = &clr_ctr_r;
  assign sts.out_free  = out_free;

endmodule

`default_nettype wire

>>> hdl/lhm_ctrl.sv
// ----------------------------------------------------------------------------
// lhm_ctrl
// Sequencer for the monitor: bucket store clearing sweep, record
// read-modify-write, percentile walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lhm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output lhm_pkg::cmd_t cmd,
  input  lhm_pkg::sts_t sts
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_STAT  = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_BRD   = 4'd4;
  localparam logic [3:0] ST_RCMT  = 4'd5;
  localparam logic [3:0] ST_TGT   = 4'd6;
  localparam logic [3:0] ST_WALK  = 4'd7;
  localparam logic [3:0] ST_QCMT  = 4'd8;
  localparam logic [3:0] ST_OCMT  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_STAT;
        end
      end
      ST_STAT: begin
        cmd.stat_rd = 1'b1;
        if (sts.oor) begin
          state_nxt = ST_OCMT;
        end else if (sts.is_query) begin
          state_nxt = ST_TGT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_BRD;
        end
      end
      ST_BRD: begin
        cmd.bkt_rd = 1'b1;
        state_nxt  = ST_RCMT;
      end
      ST_RCMT: begin
        if (sts.out_free) begin
          cmd.rec_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_TGT: begin
        cmd.tgt_load = 1'b1;
        state_nxt    = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_issue = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_QCMT;
        end
      end
      ST_QCMT: begin
        if (sts.out_free) begin
          cmd.q_commit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_OCMT: begin
        if (sts.out_free) begin
          cmd.oor_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/latency_histogram_monitor_unit.sv
// Per-slot latency monitor. A record transaction (kind 0) adds one latency
// sample to its slot: count, error count, wrapping total, peak, overflow count
// and the saturating histogram bucket latency/BUCKET_WIDTH_NS, clamped to the
// last bucket. A query transaction (kind 1) returns the upper edge of the first
// bucket where the running sum reaches ceil(count*percent/100), or 0 when it is
// never reached. Every transaction returns one result carrying the slot's
// statistics; slots at or beyond SLOTS return all zeros and change nothing.
// Items are handled one at a time. Once accepted, a record goes through the
// slot statistics read, which also starts the bucket index by reciprocal
// multiplication, then the bucket store read and the write-back. A query walks
// the buckets, one bucket store read per cycle through a three-stage accumulate
// pipeline, up to BUCKETS buckets. An out-of-range slot goes from the slot
// statistics read straight to its result. Each result waits to commit while the
// previous result is still held in the output register; the next item is
// accepted while that result is held. After reset the bucket store is swept to
// zero, all 2^(clog2(SLOTS)+clog2(BUCKETS)) entries (131072 at the default
// sizes), during which in_ready stays low.
// ----------------------------------------------------------------------------
// latency_histogram_monitor_unit
// Top level: sequencer plus statistics/histogram datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_monitor_unit #(
  parameter int SLOTS           = 64,
  parameter int BUCKETS         = 2048,
  parameter int BUCKET_WIDTH_NS = 5000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [lhm_pkg::SLOT_W-1:0]   in_metric_slot,
  input  logic [lhm_pkg::LAT_W-1:0]    in_latency_ns,
  input  logic                         in_success,
  input  logic [lhm_pkg::PCT_W-1:0]    in_percent,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lhm_pkg::CNT_W-1:0]    out_sample_count,
  output logic [lhm_pkg::CNT_W-1:0]    out_error_count,
  output logic [lhm_pkg::TOT_W-1:0]    out_latency_total,
  output logic [lhm_pkg::LAT_W-1:0]    out_latency_peak,
  output logic [lhm_pkg::CNT_W-1:0]    out_overflow_count,
  output logic [lhm_pkg::PCTL_W-1:0]   out_percentile_ns
);

  lhm_pkg::cmd_t cmd;
  lhm_pkg::sts_t sts;

  // Sequencer
  lhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Statistics and histogram datapath
  lhm_datapath #(
    .SLOTS           (SLOTS),
    .BUCKETS         (BUCKETS),
    .BUCKET_WIDTH_NS (BUCKET_WIDTH_NS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_kind),
    .in_metric_slot     (in_metric_slot),
    .in_latency_ns      (in_latency_ns),
    .in_success         (in_success),
    .in_percent         (in_percent),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_count   (out_sample_count),
    .out_error_count    (out_error_count),
    .out_latency_total  (out_latency_total),
    .out_latency_peak   (out_latency_peak),
    .out_overflow_count (out_overflow_count),
    .out_percentile_ns  (out_percentile_ns)
  );

endmodule

`default_nettype wire

>>> hdl/lhm_checker.sv
// ----------------------------------------------------------------------------
// lhm_checker
// Port-level checks of the latency histogram monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lhm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lhm_pkg::CNT_W-1:0]    out_sample_count,
  input logic [lhm_pkg::CNT_W-1:0]    out_error_count,
  input logic [lhm_pkg::TOT_W-1:0]    out_latency_total,
  input logic [lhm_pkg::LAT_W-1:0]    out_latency_peak,
  input logic [lhm_pkg::CNT_W-1:0]    out_overflow_count,
  input logic [lhm_pkg::PCTL_W-1:0]   out_percentile_ns
);

  // A stalled result stays valid with its sample count and percentile held
  `LHM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_count) && $stable(out_percentile_ns), "stalled result changed")

  // Errors and overflows never outrun the sample count
  `LHM_ASSERT_IMPLY(a_err_le_cnt, out_valid, out_error_count <= out_sample_count, "error count above sample count")
  `LHM_ASSERT_IMPLY(a_ovf_le_cnt, out_valid, out_overflow_count <= out_sample_count, "overflow count above sample count")

  // An empty slot carries no latency
  `LHM_ASSERT_IMPLY(a_empty_slot, out_valid && (out_sample_count == '0), (out_latency_total == '0) && (out_latency_peak == '0), "empty slot with latency")

  // One transaction at a time
  `LHM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken on back-to-back cycles")

endmodule

bind latency_histogram_monitor_unit lhm_checker u_lhm_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the latency histogram monitor. A queue of record and
// percentile-query transactions feeds a handshake driver; a scoreboard keeps
// its own copy of every slot's statistics and histogram, works out the result
// of each accepted transaction and compares it field by field with the block.
// ----------------------------------------------------------------------------

module testbench;

  localparam int NSLOT  = 64;
  localparam int NBKT   = 2048;
  localparam int BKT_NS = 5000;

  localparam logic KIND_RECORD = ~lhm_pkg::KIND_QUERY;

  localparam int  RANDOM_ITEMS = 680;
  localparam int  QUERY_SHARE  = 8;      // percent of random transactions
  localparam int  IDLE_SHARE   = 27;     // percent of idle cycles per side
  localparam int  CALM_FIRST   = 400;    // no idling from here ...
  localparam int  CALM_LAST    = 500;    // ... up to here
  localparam int  HOLD_AT      = 150;    // results seen before the long hold
  localparam int  HOLD_CYCLES  = 500;
  localparam int  TAIL_CYCLES  = 60;
  localparam longint LIMIT_CYCLES = 5_000_000;

  localparam logic [lhm_pkg::LAT_W-1:0] HIST_SPAN = lhm_pkg::LAT_W'(NBKT * BKT_NS);

  typedef struct packed {
    logic                        kind;
    logic [lhm_pkg::SLOT_W-1:0]  slot;
    logic [lhm_pkg::LAT_W-1:0]   lat;
    logic                        ok;
    logic [lhm_pkg::PCT_W-1:0]   pct;
    bit                          drain;   // wait for all results before sending
  } sample_t;

  typedef struct packed {
    lhm_pkg::stat_t              st;
    logic [lhm_pkg::PCTL_W-1:0]  pctl;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_kind = 1'b0;
  logic [lhm_pkg::SLOT_W-1:0]    in_metric_slot = '0;
  logic [lhm_pkg::LAT_W-1:0]     in_latency_ns = '0;
  logic                          in_success = 1'b0;
  logic [lhm_pkg::PCT_W-1:0]     in_percent = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [lhm_pkg::CNT_W-1:0]     out_sample_count;
  logic [lhm_pkg::CNT_W-1:0]     out_error_count;
  logic [lhm_pkg::TOT_W-1:0]     out_latency_total;
  logic [lhm_pkg::LAT_W-1:0]     out_latency_peak;
  logic [lhm_pkg::CNT_W-1:0]     out_overflow_count;
  logic [lhm_pkg::PCTL_W-1:0]    out_percentile_ns;

  // Scoreboard copy of the block's store
  bit [lhm_pkg::CNT_W-1:0] bin_count [NSLOT*NBKT];
  lhm_pkg::stat_t          slot_stat [NSLOT];

  sample_t      pending_samples[$];
  slot_report_t expected_reports[$];

  int     total_items     = 0;
  int     items_accepted  = 0;
  int     results_seen    = 0;
  int     mismatches      = 0;
  bit     in_took         = 1'b0;
  longint cycle_count     = 0;
  int     hold_left       = 0;
  bit     hold_done       = 1'b0;
  int     n_records       = 0;
  int     n_overflows     = 0;
  int     n_queries       = 0;
  int     n_not_found     = 0;

  latency_histogram_monitor_unit #(
    .SLOTS           (NSLOT),
    .BUCKETS         (NBKT),
    .BUCKET_WIDTH_NS (BKT_NS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_metric_slot     (in_metric_slot),
    .in_latency_ns      (in_latency_ns),
    .in_success         (in_success),
    .in_percent         (in_percent),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_count   (out_sample_count),
    .out_error_count    (out_error_count),
    .out_latency_total  (out_latency_total),
    .out_latency_peak   (out_latency_peak),
    .out_overflow_count (out_overflow_count),
    .out_percentile_ns  (out_percentile_ns)
  );

  always #5ns clk = ~clk;

  function automatic logic [lhm_pkg::CNT_W-1:0] sat_bump(logic [lhm_pkg::CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Apply one transaction to the scoreboard store and return the slot report
  function automatic slot_report_t account_sample(sample_t s);
    slot_report_t                r;
    logic [lhm_pkg::LAT_W-1:0]   bin_q;
    int                          bin;
    int                          base;
    logic [63:0]                 target;
    logic [63:0]                 running;
    bit                          found;
    r     = '0;
    base  = int'(s.slot) * NBKT;
    found = 1'b0;
    if (s.kind == lhm_pkg::KIND_QUERY) begin
      // walk buckets from the lowest until the running sum reaches the target
      target  = (64'(slot_stat[s.slot].cnt) * 64'(s.pct) + 64'd99) / 64'(lhm_pkg::PCT_SCALE);
      running = '0;
      for (int b = 0; b < NBKT && !found; b++) begin
        running += 64'(bin_count[base + b]);
        if (running >= target) begin
          r.pctl = lhm_pkg::PCTL_W'((b + 1) * BKT_NS);
          found  = 1'b1;
        end
      end
      n_queries++;
      if (!found) n_not_found++;
    end else begin
      bin_q = s.lat / lhm_pkg::LAT_W'(BKT_NS);
      bin   = (bin_q >= lhm_pkg::LAT_W'(NBKT)) ? NBKT - 1 : int'(bin_q);
      slot_stat[s.slot].cnt = sat_bump(slot_stat[s.slot].cnt);
      if (!s.ok) slot_stat[s.slot].err = sat_bump(slot_stat[s.slot].err);
      slot_stat[s.slot].tot = slot_stat[s.slot].tot + 64'(s.lat);
      if (s.lat > slot_stat[s.slot].peak) slot_stat[s.slot].peak = s.lat;
      if (s.lat >= HIST_SPAN) begin
        slot_stat[s.slot].ovf = sat_bump(slot_stat[s.slot].ovf);
        n_overflows++;
      end
      bin_count[base + bin] = sat_bump(bin_count[base + bin]);
      n_records++;
    end
    r.st = slot_stat[s.slot];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_sample(input logic kind, input int slot, input longint lat,
                              input logic ok, input int pct, input bit drain);
    sample_t s;
    s.kind  = kind;
    s.slot  = lhm_pkg::SLOT_W'(slot);
    s.lat   = lhm_pkg::LAT_W'(lat);
    s.ok    = ok;
    s.pct   = lhm_pkg::PCT_W'(pct);
    s.drain = drain;
    pending_samples.push_back(s);
  endtask

  // Driver: offer the next transaction at the falling edge, hold it until taken
  always @(negedge clk) begin : drive_input
    bit idle;
    idle = ($urandom_range(0, 99) < IDLE_SHARE) &&
           !(items_accepted >= CALM_FIRST && items_accepted < CALM_LAST);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_samples.size() != 0 && !idle &&
          (!pending_samples[0].drain || expected_reports.size() == 0)) begin
        in_valid       <= 1'b1;
        in_kind        <= pending_samples[0].kind;
        in_metric_slot <= pending_samples[0].slot;
        in_latency_ns  <= pending_samples[0].lat;
        in_success     <= pending_samples[0].ok;
        in_percent     <= pending_samples[0].pct;
        void'(pending_samples.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, a calm window and one long hold-off to fill the block
  always @(negedge clk) begin : drive_output_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (results_seen >= HOLD_AT && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_ready <= 1'b0;
    end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_SHARE);
    end
  end

  // Monitor: check results first, then predict for a newly taken transaction
  always @(posedge clk) begin : watch_ports
    slot_report_t want;
    sample_t      taken;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("sample_count",   64'(want.st.cnt),  64'(out_sample_count));
        check_field("error_count",    64'(want.st.err),  64'(out_error_count));
        check_field("latency_total",  want.st.tot,       out_latency_total);
        check_field("latency_peak",   64'(want.st.peak), 64'(out_latency_peak));
        check_field("overflow_count", 64'(want.st.ovf),  64'(out_overflow_count));
        check_field("percentile_ns",  64'(want.pctl),    64'(out_percentile_ns));
      end
    end
    in_took = rst_n && in_valid && in_ready;
    if (in_took) begin
      taken.kind  = in_kind;
      taken.slot  = in_metric_slot;
      taken.lat   = in_latency_ns;
      taken.ok    = in_success;
      taken.pct   = in_percent;
      taken.drain = 1'b0;
      expected_reports.push_back(account_sample(taken));
      items_accepted++;
    end
  end

  initial begin : stimulus
    sample_t s;
    int      pick;
    for (int k = 0; k < NSLOT; k++) slot_stat[k] = '0;

    // Bucket edges, overflow boundary, the full latency range and both flags
    queue_sample(KIND_RECORD, 0, 0,                  1'b1, 0,   1'b0);
    queue_sample(KIND_RECORD, 0, BKT_NS - 1,         1'b0, 127, 1'b0);
    queue_sample(KIND_RECORD, 0, BKT_NS,             1'b1, 0,   1'b0);
    queue_sample(KIND_RECORD, 0, NBKT * BKT_NS - 1,  1'b1, 55,  1'b0);
    queue_sample(KIND_RECORD, 0, NBKT * BKT_NS,      1'b0, 0,   1'b0);
    queue_sample(KIND_RECORD, 0, 64'hFF_FFFF_FFFF,   1'b1, 127, 1'b0);
    // Percentiles: zero, middle, full, and targets past the sample count
    queue_sample(lhm_pkg::KIND_QUERY, 0, 0,               1'b0, 0,   1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 0, 0,               1'b1, 50,  1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 0, 64'hFF_FFFF_FFFF, 1'b1, 100, 1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 0, 0,               1'b0, 101, 1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 0, 0,               1'b1, 127, 1'b0);
    // Empty slots answer with the first bucket edge whatever the percent; then records and queries on them
    queue_sample(lhm_pkg::KIND_QUERY, 63, 0,  1'b0, 0,   1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 63, 0,  1'b1, 127, 1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 5,  0,  1'b1, 100, 1'b0);
    queue_sample(KIND_RECORD, 63, 12345,      1'b0, 127, 1'b0);
    queue_sample(KIND_RECORD, 63, 7_777_777,  1'b1, 1,   1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 63, 0,  1'b0, 1,   1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 63, 0,  1'b0, 51,  1'b0);
    queue_sample(KIND_RECORD, 5, 0,           1'b0, 0,   1'b0);
    queue_sample(lhm_pkg::KIND_QUERY, 5, 0,   1'b1, 100, 1'b0);

    // Random traffic, mostly on a few hot slots to build deep histograms
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      s.kind = ($urandom_range(0, 99) < QUERY_SHARE) ? lhm_pkg::KIND_QUERY : KIND_RECORD;
      s.slot = ($urandom_range(0, 99) < 80) ? lhm_pkg::SLOT_W'($urandom_range(0, 7))
                                            : lhm_pkg::SLOT_W'($urandom_range(0, NSLOT - 1));
      pick = $urandom_range(0, 99);
      if (pick < 40)
        s.lat = lhm_pkg::LAT_W'($urandom_range(0, 50_000));
      else if (pick < 65)
        s.lat = lhm_pkg::LAT_W'($urandom_range(0, NBKT * BKT_NS - 1));
      else if (pick < 80)
        s.lat = lhm_pkg::LAT_W'($urandom_range(1, NBKT) * BKT_NS - 1 + $urandom_range(0, 2));
      else if (pick < 90)
        s.lat = HIST_SPAN + lhm_pkg::LAT_W'($urandom_range(0, 1_000_000));
      else
        s.lat = {8'($urandom), 32'($urandom)};
      s.ok = ($urandom_range(0, 99) < 75);
      if (s.kind == lhm_pkg::KIND_QUERY && $urandom_range(0, 99) < 85)
        s.pct = lhm_pkg::PCT_W'($urandom_range(0, lhm_pkg::PCT_SCALE));
      else if (s.kind == lhm_pkg::KIND_QUERY)
        s.pct = lhm_pkg::PCT_W'($urandom_range(lhm_pkg::PCT_SCALE + 1, 127));
      else
        s.pct = lhm_pkg::PCT_W'($urandom_range(0, 127));
      // pause the sender until drained at a few points
      s.drain = (n == 0 || n == 250 || n == 600);
      pending_samples.push_back(s);
    end
    total_items = pending_samples.size();

    // Hold reset, then release on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while ((items_accepted < total_items || expected_reports.size() != 0) &&
           cycle_count < LIMIT_CYCLES)
      @(negedge clk);

    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_reports.size());
      $display("Verification failed");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (expected_reports.size() != 0) begin
        $error("%0d results never arrived", expected_reports.size());
        mismatches++;
      end
      $display("Ran %0d records (%0d beyond the histogram) and %0d percentile queries",
               n_records, n_overflows, n_queries);
      $display("(%0d with no bucket reaching the target) in %0d cycles, %0d mismatches",
               n_not_found, cycle_count, mismatches);
      if (mismatches == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule

>>> latency_histogram_monitor_unit.f
+incdir+hdl
hdl/lhm_pkg.sv
hdl/lhm_div.sv
hdl/lhm_datapath.sv
hdl/lhm_ctrl.sv
hdl/latency_histogram_monitor_unit.sv
hdl/lhm_checker.sv
bench/testbench.sv
